// ===== rtl/mcpt_pkg.sv =====
// mcpt_pkg: shared types and constants of the mask centroid path tracker
// register map, reset values and the configuration struct; no dependencies

package mcpt_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int DIM_CFG_W  = 11;
   localparam int BAND_CFG_W = 10;
   localparam int PIX_W      = 8;

   localparam int ROW_OUT_W   = 10;
   localparam int COL_OUT_W   = 10;
   localparam int COUNT_OUT_W = 21;
   localparam int PATH_W      = 32;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [DIM_CFG_W-1:0]  RST_FRAME_WIDTH      = 11'd768;
   localparam logic [DIM_CFG_W-1:0]  RST_FRAME_HEIGHT     = 11'd576;
   localparam logic [BAND_CFG_W-1:0] RST_BORDER_BAND      = 10'd17;
   localparam logic [PIX_W-1:0]      RST_FOREGROUND_LEVEL = 8'd255;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH      = 2'd0,
      REG_FRAME_HEIGHT     = 2'd1,
      REG_BORDER_BAND      = 2'd2,
      REG_FOREGROUND_LEVEL = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [DIM_CFG_W-1:0]  frame_width;
      logic [DIM_CFG_W-1:0]  frame_height;
      logic [BAND_CFG_W-1:0] border_band;
      logic [PIX_W-1:0]      foreground_level;
   } cfg_type;

endpackage

// ===== rtl/mcpt_front.sv =====
// mcpt_front: raster position tracking and per-frame foreground accumulation
// pushes one frame summary (row sum, column sum, count) per frame; uses mcpt_pkg

module mcpt_front #(
   parameter int MAX_WIDTH  = mcpt_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = mcpt_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mcpt_pkg::cfg_type                    cfg,
   input  logic                                 pix_accept,
   input  logic [mcpt_pkg::PIX_W-1:0]           pix_value,
   output logic                                 push,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)
                 + ((MAX_WIDTH > MAX_HEIGHT) ? $clog2(MAX_WIDTH)
                                             : $clog2(MAX_HEIGHT))-1:0] push_row_sum,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)
                 + ((MAX_WIDTH > MAX_HEIGHT) ? $clog2(MAX_WIDTH)
                                             : $clog2(MAX_HEIGHT))-1:0] push_col_sum,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0]                   push_count
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int QW    = (CW > RW) ? CW : RW;
   localparam int CNT_W = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
   localparam int SUM_W = CNT_W + QW;
   localparam int DIM_W = (QW + 1 > mcpt_pkg::DIM_CFG_W) ? QW + 1 : mcpt_pkg::DIM_CFG_W;

   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [SUM_W-1:0] rsum_ff, rsum_in, csum_ff, csum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [DIM_W-1:0] fw, fh, w, h;
   logic             last_col, last_row, in_band, hit;
   logic [SUM_W-1:0] rsum_acc, csum_acc;
   logic [CNT_W-1:0] cnt_acc;

   always_comb begin
      fw = DIM_W'(cfg.frame_width);
      fh = DIM_W'(cfg.frame_height);
      if (fw == '0) begin
         w = DIM_W'(1);
      end else if (fw > DIM_W'(MAX_WIDTH)) begin
         w = DIM_W'(MAX_WIDTH);
      end else begin
         w = fw;
      end
      if (fh == '0) begin
         h = DIM_W'(1);
      end else if (fh > DIM_W'(MAX_HEIGHT)) begin
         h = DIM_W'(MAX_HEIGHT);
      end else begin
         h = fh;
      end

      // a position already past a shrunken limit also closes the row or frame
      last_col = (DIM_W'(col_ff) + DIM_W'(1)) >= w;
      last_row = (DIM_W'(row_ff) + DIM_W'(1)) >= h;
      in_band  = (DIM_W'(row_ff) <= DIM_W'(cfg.border_band)) ||
                 (DIM_W'(col_ff) <= DIM_W'(cfg.border_band));
      hit      = !in_band && (pix_value == cfg.foreground_level);

      rsum_acc = hit ? rsum_ff + SUM_W'(row_ff) : rsum_ff;
      csum_acc = hit ? csum_ff + SUM_W'(col_ff) : csum_ff;
      cnt_acc  = hit ? cnt_ff + CNT_W'(1) : cnt_ff;

      col_in  = col_ff;
      row_in  = row_ff;
      rsum_in = rsum_ff;
      csum_in = csum_ff;
      cnt_in  = cnt_ff;
      push    = 1'b0;
      if (pix_accept) begin
         rsum_in = rsum_acc;
         csum_in = csum_acc;
         cnt_in  = cnt_acc;
         if (!last_col) begin
            col_in = col_ff + CW'(1);
         end else begin
            col_in = '0;
            if (!last_row) begin
               row_in = row_ff + RW'(1);
            end else begin
               row_in  = '0;
               push    = 1'b1;
               rsum_in = '0;
               csum_in = '0;
               cnt_in  = '0;
            end
         end
      end
   end

   assign push_row_sum = rsum_acc;
   assign push_col_sum = csum_acc;
   assign push_count   = cnt_acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         rsum_ff <= '0;
         csum_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         rsum_ff <= rsum_in;
         csum_ff <= csum_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ===== rtl/mcpt_queue.sv =====
// mcpt_queue: two-entry queue of frame summaries between front and back
// generic payload width; no package dependencies

module mcpt_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full     = fill_ff == 2'd2;
   assign empty    = fill_ff == 2'd0;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== rtl/mcpt_back.sv =====
// mcpt_back: per-frame centroid division, distance square root and path update
// one shared restoring divider, one digit-serial square root; uses mcpt_pkg

module mcpt_back #(
   parameter int MAX_WIDTH  = mcpt_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = mcpt_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_empty,
   input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)
                 + ((MAX_WIDTH > MAX_HEIGHT) ? $clog2(MAX_WIDTH)
                                             : $clog2(MAX_HEIGHT))-1:0] q_row_sum,
   input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)
                 + ((MAX_WIDTH > MAX_HEIGHT) ? $clog2(MAX_WIDTH)
                                             : $clog2(MAX_HEIGHT))-1:0] q_col_sum,
   input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0]                   q_count,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mcpt_pkg::ROW_OUT_W-1:0]       rsp_centroid_row,
   output logic [mcpt_pkg::COL_OUT_W-1:0]       rsp_centroid_col,
   output logic                                 rsp_found,
   output logic [mcpt_pkg::COUNT_OUT_W-1:0]     rsp_pixel_count,
   output logic [mcpt_pkg::PATH_W-1:0]          rsp_path_length
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int RW     = $clog2(MAX_HEIGHT);
   localparam int QW     = (CW > RW) ? CW : RW;
   localparam int CNT_W  = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
   localparam int SUM_W  = CNT_W + QW;
   localparam int DV_W   = SUM_W + 1;
   localparam int SW     = QW + 1;
   localparam int RT_W   = 2 * SW;
   localparam int STEP_W = $clog2(SW + 1);
   localparam int PW     = mcpt_pkg::PATH_W;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DIV      = 7'b0000010,
      ST_DIFF     = 7'b0000100,
      ST_SQR_ROW  = 7'b0001000,
      ST_SQR_COL  = 7'b0010000,
      ST_ROOT     = 7'b0100000,
      ST_DONE     = 7'b1000000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [SUM_W-1:0]  csum_ff, csum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DV_W-1:0]   num_ff, num_in, den_ff, den_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic              div_col_ff, div_col_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [QW-1:0]     crow_ff, crow_in, ccol_ff, ccol_in;
   logic [QW-1:0]     dr_ff, dr_in, dc_ff, dc_in;
   logic [RT_W-1:0]   rem_ff, rem_in, root_ff, root_in, bit_ff, bit_in;
   logic [SW-1:0]     dist_ff, dist_in;
   logic              add_dist_ff, add_dist_in;
   logic              found_ff, found_in;
   logic [QW-1:0]     last_row_ff, last_row_in, last_col_ff, last_col_in;
   logic              have_last_ff, have_last_in;
   logic [PW-1:0]     path_ff, path_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [mcpt_pkg::ROW_OUT_W-1:0]      rsp_row_ff, rsp_row_in;
   logic [mcpt_pkg::COL_OUT_W-1:0]      rsp_col_ff, rsp_col_in;
   logic                                rsp_found_ff, rsp_found_in;
   logic [mcpt_pkg::COUNT_OUT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [PW-1:0]                       rsp_path_ff, rsp_path_in;

   logic              div_ge;
   logic [QW-1:0]     quo_next;
   logic [QW-1:0]     mul_op;
   logic [2*QW-1:0]   sq;
   logic [RT_W-1:0]   trial, rem_next, root_next;
   logic [PW:0]       path_sum;
   logic [PW-1:0]     path_new;
   logic [31:0]       crow_wide, ccol_wide, cnt_wide;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign crow_wide = 32'(crow_ff);
   assign ccol_wide = 32'(ccol_ff);
   assign cnt_wide  = 32'(cnt_ff);

   // shared datapath pieces
   always_comb begin
      div_ge    = num_ff >= den_ff;
      quo_next  = QW'({quo_ff, div_ge});
      mul_op    = (state_ff == ST_SQR_ROW) ? dr_ff : dc_ff;
      sq        = mul_op * mul_op;
      trial     = root_ff + bit_ff;
      if (rem_ff >= trial) begin
         rem_next  = rem_ff - trial;
         root_next = (root_ff >> 1) + bit_ff;
      end else begin
         rem_next  = rem_ff;
         root_next = root_ff >> 1;
      end
      path_sum = {1'b0, path_ff} + (PW+1)'(dist_ff);
      path_new = path_ff;
      if (add_dist_ff) begin
         path_new = path_sum[PW] ? '1 : path_sum[PW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      csum_in      = csum_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      div_col_in   = div_col_ff;
      step_in      = step_ff;
      crow_in      = crow_ff;
      ccol_in      = ccol_ff;
      dr_in        = dr_ff;
      dc_in        = dc_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      dist_in      = dist_ff;
      add_dist_in  = add_dist_ff;
      found_in     = found_ff;
      last_row_in  = last_row_ff;
      last_col_in  = last_col_ff;
      have_last_in = have_last_ff;
      path_in      = path_ff;
      q_pop        = 1'b0;

      rsp_valid_in = (rsp_valid_ff && rsp_stall);
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_found_in = rsp_found_ff;
      rsp_count_in = rsp_count_ff;
      rsp_path_in  = rsp_path_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop       = 1'b1;
               csum_in     = q_col_sum;
               cnt_in      = q_count;
               add_dist_in = 1'b0;
               if (q_count == '0) begin
                  found_in = 1'b0;
                  crow_in  = '0;
                  ccol_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  // round(sum / n) as (2 sum + n) / 2n
                  found_in   = 1'b1;
                  num_in     = DV_W'({q_row_sum, 1'b0}) + DV_W'(q_count);
                  den_in     = DV_W'({q_count, 1'b0}) << (QW - 1);
                  quo_in     = '0;
                  div_col_in = 1'b0;
                  step_in    = STEP_W'(QW - 1);
                  state_in   = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            num_in = div_ge ? num_ff - den_ff : num_ff;
            den_in = den_ff >> 1;
            quo_in = quo_next;
            if (step_ff != '0) begin
               step_in = step_ff - STEP_W'(1);
            end else if (!div_col_ff) begin
               crow_in    = quo_next;
               num_in     = DV_W'({csum_ff, 1'b0}) + DV_W'(cnt_ff);
               den_in     = DV_W'({cnt_ff, 1'b0}) << (QW - 1);
               quo_in     = '0;
               div_col_in = 1'b1;
               step_in    = STEP_W'(QW - 1);
            end else begin
               ccol_in     = quo_next;
               add_dist_in = have_last_ff;
               state_in    = have_last_ff ? ST_DIFF : ST_DONE;
            end
         end
         ST_DIFF: begin
            dr_in    = (crow_ff > last_row_ff) ? crow_ff - last_row_ff : last_row_ff - crow_ff;
            dc_in    = (ccol_ff > last_col_ff) ? ccol_ff - last_col_ff : last_col_ff - ccol_ff;
            state_in = ST_SQR_ROW;
         end
         ST_SQR_ROW: begin
            rem_in   = RT_W'(sq);
            state_in = ST_SQR_COL;
         end
         ST_SQR_COL: begin
            rem_in   = rem_ff + RT_W'(sq);
            root_in  = '0;
            bit_in   = RT_W'(1) << (RT_W - 2);
            step_in  = STEP_W'(SW - 1);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rem_in  = rem_next;
            root_in = root_next;
            bit_in  = bit_ff >> 2;
            if (step_ff != '0) begin
               step_in = step_ff - STEP_W'(1);
            end else begin
               // round half up: bump when remainder exceeds the floor root
               dist_in  = (rem_next > root_next) ? SW'(root_next + RT_W'(1))
                                                 : SW'(root_next);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               path_in = path_new;
               if (found_ff) begin
                  last_row_in  = crow_ff;
                  last_col_in  = ccol_ff;
                  have_last_in = 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_row_in   = crow_wide[mcpt_pkg::ROW_OUT_W-1:0];
               rsp_col_in   = ccol_wide[mcpt_pkg::COL_OUT_W-1:0];
               rsp_found_in = found_ff;
               rsp_count_in = cnt_wide[mcpt_pkg::COUNT_OUT_W-1:0];
               rsp_path_in  = path_new;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_last_ff <= 1'b0;
         last_row_ff  <= '0;
         last_col_ff  <= '0;
         path_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_last_ff <= have_last_in;
         last_row_ff  <= last_row_in;
         last_col_ff  <= last_col_in;
         path_ff      <= path_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      csum_ff     <= csum_in;
      cnt_ff      <= cnt_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      quo_ff      <= quo_in;
      div_col_ff  <= div_col_in;
      step_ff     <= step_in;
      crow_ff     <= crow_in;
      ccol_ff     <= ccol_in;
      dr_ff       <= dr_in;
      dc_ff       <= dc_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      dist_ff     <= dist_in;
      add_dist_ff <= add_dist_in;
      found_ff    <= found_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in;
      rsp_path_ff  <= rsp_path_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_centroid_row = rsp_row_ff;
   assign rsp_centroid_col = rsp_col_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_pixel_count  = rsp_count_ff;
   assign rsp_path_length  = rsp_path_ff;

endmodule

// ===== rtl/mask_centroid_path_tracker.sv =====
// mask_centroid_path_tracker: top level with register file, front, queue and back
// depends on mcpt_pkg, mcpt_front, mcpt_queue, mcpt_back
//
//   port group  | dir | handshake             | beat contents
//   req_*       | in  | req_valid / req_stall | pixel_value, one mask pixel in raster order
//   rsp_*       | out | rsp_valid / rsp_stall | centroid row/col, found, pixel count, path length
//   psel...     | in  | psel/penable, pready  | four config registers at byte offsets 0,4,8,12
//
// one pixel beat per cycle while req_stall is low; a frame summary goes to a two-entry queue at the last pixel
// a frame with a previous centroid runs both divisions on the shared bit-per-cycle divider,
// then the digit-serial square root of the squared distance to the previous centroid
// the first centroid skips the root, and an empty frame skips the divisions as well
// req_stall is high only while the queue holds two frames not yet taken by the back
// synchronous reset, active high; no clearing pass

module mask_centroid_path_tracker #(
   parameter int MAX_WIDTH  = mcpt_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = mcpt_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mcpt_pkg::PIX_W-1:0]          req_pixel_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mcpt_pkg::ROW_OUT_W-1:0]      rsp_centroid_row,
   output logic [mcpt_pkg::COL_OUT_W-1:0]      rsp_centroid_col,
   output logic                                rsp_found,
   output logic [mcpt_pkg::COUNT_OUT_W-1:0]    rsp_pixel_count,
   output logic [mcpt_pkg::PATH_W-1:0]         rsp_path_length,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mcpt_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [mcpt_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [mcpt_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int RW     = $clog2(MAX_HEIGHT);
   localparam int QW     = (CW > RW) ? CW : RW;
   localparam int CNT_W  = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
   localparam int SUM_W  = CNT_W + QW;
   localparam int ENTRY_W = 2 * SUM_W + CNT_W;

   mcpt_pkg::cfg_type       cfg_ff, cfg_in;
   mcpt_pkg::reg_index_type reg_sel;
   logic                    csr_write;

   logic             pix_accept;
   logic             push, q_full, q_empty, q_pop;
   logic [SUM_W-1:0] push_row_sum, push_col_sum, q_row_sum, q_col_sum;
   logic [CNT_W-1:0] push_count, q_count;
   logic [ENTRY_W-1:0] push_data, pop_data;

   // register file
   assign pready    = 1'b1;
   assign reg_sel   = mcpt_pkg::reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_sel)
            mcpt_pkg::REG_FRAME_WIDTH:
               cfg_in.frame_width = pwdata[mcpt_pkg::DIM_CFG_W-1:0];
            mcpt_pkg::REG_FRAME_HEIGHT:
               cfg_in.frame_height = pwdata[mcpt_pkg::DIM_CFG_W-1:0];
            mcpt_pkg::REG_BORDER_BAND:
               cfg_in.border_band = pwdata[mcpt_pkg::BAND_CFG_W-1:0];
            mcpt_pkg::REG_FOREGROUND_LEVEL:
               cfg_in.foreground_level = pwdata[mcpt_pkg::PIX_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         mcpt_pkg::REG_FRAME_WIDTH:      prdata = 32'(cfg_ff.frame_width);
         mcpt_pkg::REG_FRAME_HEIGHT:     prdata = 32'(cfg_ff.frame_height);
         mcpt_pkg::REG_BORDER_BAND:      prdata = 32'(cfg_ff.border_band);
         mcpt_pkg::REG_FOREGROUND_LEVEL: prdata = 32'(cfg_ff.foreground_level);
         default:                        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width      <= mcpt_pkg::RST_FRAME_WIDTH;
         cfg_ff.frame_height     <= mcpt_pkg::RST_FRAME_HEIGHT;
         cfg_ff.border_band      <= mcpt_pkg::RST_BORDER_BAND;
         cfg_ff.foreground_level <= mcpt_pkg::RST_FOREGROUND_LEVEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front accepts pixels until the queue is full
   assign req_stall  = q_full;
   assign pix_accept = req_valid && !req_stall;

   mcpt_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .pix_accept   (pix_accept),
      .pix_value    (req_pixel_value),
      .push         (push),
      .push_row_sum (push_row_sum),
      .push_col_sum (push_col_sum),
      .push_count   (push_count)
   );

   assign push_data = {push_row_sum, push_col_sum, push_count};

   mcpt_queue #(
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (pop_data)
   );

   assign q_row_sum = pop_data[ENTRY_W-1 -: SUM_W];
   assign q_col_sum = pop_data[CNT_W +: SUM_W];
   assign q_count   = pop_data[CNT_W-1:0];

   mcpt_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_row_sum        (q_row_sum),
      .q_col_sum        (q_col_sum),
      .q_count          (q_count),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_centroid_row (rsp_centroid_row),
      .rsp_centroid_col (rsp_centroid_col),
      .rsp_found        (rsp_found),
      .rsp_pixel_count  (rsp_pixel_count),
      .rsp_path_length  (rsp_path_length)
   );

endmodule

// ===== rtl/mcpt_checker.sv =====
// mcpt_checker: port-level checks of the mask centroid path tracker
// bound to mask_centroid_path_tracker below; no package dependencies

module mcpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [9:0]  rsp_centroid_row,
   input logic [9:0]  rsp_centroid_col,
   input logic        rsp_found,
   input logic [20:0] rsp_pixel_count,
   input logic [31:0] rsp_path_length
);

   logic        rsp_beat;
   logic [31:0] last_path_ff;

   assign rsp_beat = rsp_valid && !rsp_stall;

   // path length of the last delivered beat
   always_ff @(posedge clock) begin
      if (reset) begin
         last_path_ff <= '0;
      end else if (rsp_beat) begin
         last_path_ff <= rsp_path_length;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_path_length)
                                 && $stable(rsp_pixel_count))
      else $error("stalled result beat changed");

   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_centroid_row == 10'd0 && rsp_centroid_col == 10'd0
                                  && rsp_pixel_count == 21'd0)
      else $error("empty frame result carries a centroid or a count");

   a_path_monotonic: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> rsp_path_length >= last_path_ff)
      else $error("path length went down");

   a_empty_path: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && !rsp_found |-> rsp_path_length == last_path_ff)
      else $error("empty frame changed the path length");

endmodule

bind mask_centroid_path_tracker mcpt_checker u_mcpt_checker (.*);
